FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file nusd_check.sv.
// Depends on nothing; clock and reset are passed in by the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/nusd_pkg.sv
// Types and constants of the NAL unit splitter/deduplicator.
// No dependencies.
`default_nettype none

package nusd_pkg;

  localparam int MAX_RESULTS = 5;
  localparam int CNT_W       = 3;
  localparam int SUB_LEN_W   = 24;
  localparam int NAL_TYPE_W  = 5;

  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DESC    = 2'd1;
  localparam logic [1:0] KIND_RAW     = 2'd2;

  localparam logic [SUB_LEN_W-1:0]  SUB_LEN_MAX = {SUB_LEN_W{1'b1}};
  localparam logic [NAL_TYPE_W-1:0] TYPE_SEI    = 5'd6;
  localparam logic [NAL_TYPE_W-1:0] TYPE_SPS    = 5'd7;
  localparam logic [NAL_TYPE_W-1:0] TYPE_PPS    = 5'd8;
  localparam logic [7:0]            START_LAST  = 8'h01;

  typedef struct packed {
    logic [1:0]            kind;
    logic [7:0]            data;
    logic [NAL_TYPE_W-1:0] utype;
    logic [SUB_LEN_W-1:0]  ulen;
    logic                  err;
  } result_t;

  typedef struct packed {
    cnt_t                          cnt;
    result_t [MAX_RESULTS-1:0]     res;
  } burst_t;

endpackage

`default_nettype wire

FILE: rtl/core/nusd_parse.sv
// Parse state and per-byte result generation.
// Depends on nusd_pkg.
`default_nettype none

module nusd_parse #(
  parameter int LEN_BITS = 24
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [7:0]     data_byte,
  input  wire logic           first_in_packet,
  input  wire logic           last_in_packet,
  output nusd_pkg::burst_t    burst
);

  typedef enum logic [1:0] {PH_PREFIX, PH_PAYLOAD, PH_RAW} phase_t;

  phase_t                            phase, phase_next;
  logic [1:0]                        pcount, pcount_next;
  logic [LEN_BITS-1:0]               rem, rem_next;
  logic                              ovf, ovf_next;
  logic [1:0]                        zrun, zrun_next;
  logic                              awaiting, awaiting_next;
  logic                              keep, keep_next;
  logic [nusd_pkg::NAL_TYPE_W-1:0]   stype, stype_next;
  logic [nusd_pkg::SUB_LEN_W-1:0]    slen, slen_next;
  logic [2:0]                        seen, seen_next;

  phase_t                            e_phase;
  logic [1:0]                        e_pcount, e_zrun, zr_after;
  logic [LEN_BITS-1:0]               e_rem;
  logic                              e_ovf, e_await, e_keep;
  logic [nusd_pkg::NAL_TYPE_W-1:0]   e_stype, t_first, stype_post;
  logic [nusd_pkg::SUB_LEN_W-1:0]    e_slen, slen_post;
  logic [nusd_pkg::SUB_LEN_W:0]      len_sum;
  logic [LEN_BITS+7:0]               shifted;
  logic                              complete, bad, unit_end, do_close;
  logic                              case_d, case_sc, decide, keep_t, keep_eff;
  logic                              have1, have2, err2, v_a, v_b;
  logic [2:0]                        seen_bit;
  nusd_pkg::cnt_t                    n_a, n_c, n_commit, k_cnt;
  nusd_pkg::result_t                 r_a, r_b, r_c;

  always_comb begin
    e_phase  = first_in_packet ? PH_PREFIX : phase;
    e_pcount = first_in_packet ? 2'd0 : pcount;
    e_rem    = first_in_packet ? '0 : rem;
    e_ovf    = first_in_packet ? 1'b0 : ovf;
    e_zrun   = first_in_packet ? 2'd0 : zrun;
    e_await  = first_in_packet | awaiting;
    e_keep   = first_in_packet | keep;
    e_stype  = first_in_packet ? '0 : stype;
    e_slen   = first_in_packet ? '0 : slen;

    phase_next    = e_phase;
    pcount_next   = e_pcount;
    rem_next      = e_rem;
    ovf_next      = e_ovf;
    zrun_next     = e_zrun;
    awaiting_next = e_await;
    keep_next     = e_keep;
    stype_next    = e_stype;
    slen_next     = e_slen;
    seen_next     = seen;
    burst         = '0;

    shifted  = {e_rem, data_byte};
    complete = (e_pcount == 2'd3);
    bad      = (e_ovf | (|shifted[LEN_BITS+7:LEN_BITS])) || (shifted[LEN_BITS-1:0] == '0);

    unit_end = ((e_rem - LEN_BITS'(1)) == '0);
    do_close = unit_end | last_in_packet;
    case_sc  = (data_byte == nusd_pkg::START_LAST) && (e_zrun == 2'd3);
    case_d   = 1'b0;
    n_a      = '0;
    zr_after = 2'd0;
    if (data_byte == 8'h00) begin
      if (e_zrun != 2'd3) begin
        zr_after = e_zrun + 2'd1;
      end else begin
        zr_after = 2'd3;
        n_a      = nusd_pkg::cnt_t'(1);
      end
    end else if (!case_sc) begin
      case_d = 1'b1;
      n_a    = {1'b0, e_zrun} + nusd_pkg::cnt_t'(1);
    end
    n_c      = do_close ? {1'b0, zr_after} : '0;
    n_commit = n_a + n_c;

    t_first  = (case_d && e_zrun == 2'd0) ? data_byte[nusd_pkg::NAL_TYPE_W-1:0] : '0;
    seen_bit = {t_first == nusd_pkg::TYPE_PPS, t_first == nusd_pkg::TYPE_SPS,
                t_first == nusd_pkg::TYPE_SEI};
    keep_t   = ((seen_bit & seen) == 3'b000);
    decide   = e_await && (n_commit != '0);
    keep_eff = decide ? keep_t : e_keep;
    stype_post = decide ? t_first : e_stype;
    len_sum  = {1'b0, e_slen} + (nusd_pkg::SUB_LEN_W + 1)'(n_commit);
    slen_post = len_sum[nusd_pkg::SUB_LEN_W] ? nusd_pkg::SUB_LEN_MAX
                                             : len_sum[nusd_pkg::SUB_LEN_W-1:0];
    k_cnt    = keep_eff ? n_commit : '0;

    have1 = case_sc && !e_await && e_keep && (e_slen != '0);
    have2 = !case_sc && !(e_await && !decide) && keep_eff && (slen_post != '0);
    err2  = last_in_packet && !unit_end;
    v_a   = have1;
    v_b   = do_close && (have2 || err2);

    r_a       = '0;
    r_a.kind  = nusd_pkg::KIND_DESC;
    r_a.utype = e_stype;
    r_a.ulen  = e_slen;
    r_b       = '0;
    r_b.kind  = nusd_pkg::KIND_DESC;
    r_b.utype = have2 ? stype_post : '0;
    r_b.ulen  = have2 ? slen_post : '0;
    r_b.err   = err2;
    r_c       = '0;
    r_c.kind  = nusd_pkg::KIND_PAYLOAD;

    case (e_phase)
      PH_RAW: begin
        burst.cnt           = nusd_pkg::cnt_t'(1);
        burst.res[0].kind   = nusd_pkg::KIND_RAW;
        burst.res[0].data   = data_byte;
        burst.res[0].err    = 1'b1;
      end
      PH_PAYLOAD: begin
        rem_next = e_rem - LEN_BITS'(1);
        if (decide) begin
          awaiting_next = 1'b0;
          stype_next    = t_first;
          keep_next     = keep_t;
          seen_next     = seen | seen_bit;
        end
        slen_next = slen_post;
        zrun_next = zr_after;
        if (case_sc || do_close) begin
          awaiting_next = 1'b1;
          keep_next     = 1'b1;
          stype_next    = '0;
          slen_next     = '0;
        end
        if (unit_end) begin
          phase_next  = PH_PREFIX;
          pcount_next = 2'd0;
          zrun_next   = 2'd0;
        end
        for (int i = 0; i < nusd_pkg::MAX_RESULTS; i++) begin
          if (nusd_pkg::cnt_t'(i) < k_cnt) begin
            burst.res[i]      = r_c;
            burst.res[i].data = (case_d && nusd_pkg::cnt_t'(i) == n_commit - nusd_pkg::cnt_t'(1))
                                ? data_byte : 8'h00;
          end else if (nusd_pkg::cnt_t'(i) == k_cnt && v_a) begin
            burst.res[i] = r_a;
          end else begin
            burst.res[i] = r_b;
          end
        end
        burst.cnt = k_cnt + nusd_pkg::cnt_t'(v_a) + nusd_pkg::cnt_t'(v_b);
      end
      default: begin
        rem_next    = shifted[LEN_BITS-1:0];
        ovf_next    = e_ovf | (|shifted[LEN_BITS+7:LEN_BITS]);
        pcount_next = e_pcount + 2'd1;
        if (complete) begin
          phase_next = bad ? PH_RAW : PH_PAYLOAD;
          zrun_next  = 2'd0;
        end
        burst.res[0].kind = nusd_pkg::KIND_DESC;
        burst.res[0].err  = 1'b1;
        burst.cnt = ((complete && bad) || last_in_packet) ? nusd_pkg::cnt_t'(1) : '0;
      end
    endcase

    if (last_in_packet) begin
      phase_next    = PH_PREFIX;
      pcount_next   = 2'd0;
      rem_next      = '0;
      ovf_next      = 1'b0;
      zrun_next     = 2'd0;
      awaiting_next = 1'b1;
      keep_next     = 1'b1;
      stype_next    = '0;
      slen_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_PREFIX;
      pcount   <= 2'd0;
      rem      <= '0;
      ovf      <= 1'b0;
      zrun     <= 2'd0;
      awaiting <= 1'b1;
      keep     <= 1'b1;
      stype    <= '0;
      slen     <= '0;
      seen     <= 3'b000;
    end else if (accept) begin
      phase    <= phase_next;
      pcount   <= pcount_next;
      rem      <= rem_next;
      ovf      <= ovf_next;
      zrun     <= zrun_next;
      awaiting <= awaiting_next;
      keep     <= keep_next;
      stype    <= stype_next;
      slen     <= slen_next;
      seen     <= seen_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nusd_queue.sv
// Burst register and output register: drains one result per transfer.
// Depends on nusd_pkg.
`default_nettype none

module nusd_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            byte_valid,
  output logic                 byte_stall,
  output logic                 accept,
  input  wire nusd_pkg::burst_t burst,
  output logic                 res_valid,
  input  wire logic            res_stall,
  output nusd_pkg::result_t    res,
  output logic                 res_last
);

  logic                                             a_busy;
  nusd_pkg::cnt_t                                   a_cnt;
  nusd_pkg::cnt_t                                   a_idx;
  nusd_pkg::result_t [nusd_pkg::MAX_RESULTS-1:0]    a_res;
  logic                                             a_move, a_last, a_done, take;

  assign a_move     = a_busy && (!res_valid || !res_stall);
  assign a_last     = (a_idx == a_cnt - nusd_pkg::cnt_t'(1));
  assign a_done     = a_move && a_last;
  assign take       = !a_busy || a_done;
  assign byte_stall = !take;
  assign accept     = byte_valid && take;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_busy    <= 1'b0;
      a_idx     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept && burst.cnt != '0) begin
        a_busy <= 1'b1;
        a_idx  <= '0;
      end else if (a_done) begin
        a_busy <= 1'b0;
      end else if (a_move) begin
        a_idx <= a_idx + nusd_pkg::cnt_t'(1);
      end
      if (a_move) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && burst.cnt != '0) begin
      a_cnt <= burst.cnt;
      a_res <= burst.res;
    end
    if (a_move) begin
      res      <= a_res[a_idx];
      res_last <= a_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nal_unit_splitter_deduplicator_top.sv
// Throughput: one byte per cycle while each byte yields at most one result and
// res_stall is low; a byte with n results (up to 5) holds the next transfer
// until all n of its results have moved to the output register.
// Reset: synchronous; clears parse state, seen-type flags and queued results.
// Top level of the NAL unit splitter/deduplicator; uses nusd_parse, nusd_queue.
`default_nettype none

module nal_unit_splitter_deduplicator_top #(
  parameter int LEN_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_in_packet,
  input  wire logic        last_in_packet,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [1:0]       kind,
  output logic [7:0]       out_byte,
  output logic [4:0]       unit_type,
  output logic [23:0]      unit_length,
  output logic             error,
  output logic             last_of_run
);

  logic               accept;
  nusd_pkg::burst_t   burst;
  nusd_pkg::result_t  res;

  nusd_parse #(.LEN_BITS(LEN_BITS)) u_parse (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .data_byte       (data_byte),
    .first_in_packet (first_in_packet),
    .last_in_packet  (last_in_packet),
    .burst           (burst)
  );

  nusd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .accept     (accept),
    .burst      (burst),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .res_last   (last_of_run)
  );

  assign kind        = res.kind;
  assign out_byte    = res.data;
  assign unit_type   = res.utype;
  assign unit_length = res.ulen;
  assign error       = res.err;

endmodule

`default_nettype wire

FILE: rtl/core/nusd_check.sv
// Port-level checker for nal_unit_splitter_deduplicator_top, bound to it below.
// Depends on assert_macros.svh and nusd_pkg.
`default_nettype none
`include "assert_macros.svh"

module nusd_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire logic [1:0]  kind,
  input wire logic [7:0]  out_byte,
  input wire logic [4:0]  unit_type,
  input wire logic [23:0] unit_length,
  input wire logic        error,
  input wire logic        last_of_run
);

  logic        is_pay, is_raw, is_desc, stalled;
  logic        pay_clean, raw_ok, desc_ok;
  logic [40:0] res_word;

  assign is_pay    = res_valid && (kind == nusd_pkg::KIND_PAYLOAD);
  assign is_raw    = res_valid && (kind == nusd_pkg::KIND_RAW);
  assign is_desc   = res_valid && (kind == nusd_pkg::KIND_DESC) && !error;
  assign stalled   = res_valid && res_stall;
  assign pay_clean = !error && (unit_type == '0) && (unit_length == '0);
  assign raw_ok    = error && last_of_run;
  assign desc_ok   = (unit_length != '0) && (out_byte == 8'd0);
  assign res_word  = {kind, out_byte, unit_type, unit_length, error, last_of_run};

  `ASSERT_IMP(a_payload_clean, clk, rst, is_pay, pay_clean, "payload with descriptor fields")
  `ASSERT_IMP(a_raw_single, clk, rst, is_raw, raw_ok, "raw byte not flagged or not alone")
  `ASSERT_IMP(a_desc_len, clk, rst, is_desc, desc_ok, "clean descriptor without length")
  `ASSERT_NXT(a_hold, clk, rst, stalled, res_valid && $stable(res_word), "stall broken")

endmodule

bind nal_unit_splitter_deduplicator_top nusd_check u_check (.*);

`default_nettype wire
